>>> sv/adk_pkg.sv
// types and codes shared by the antidictionary key table
package adk_pkg;

    typedef enum logic [1:0] {
        ACT_LEARN  = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] key;
        logic        bit_tag;
    } t_in_word;

    typedef struct packed {
        logic        found;
        logic        predicted_bit;
        logic        removed;
        logic        store_full;
        logic [10:0] occupancy;
    } t_out_word;

endpackage

>>> sv/adk_ram.sv
// single port pair ram with registered read data
module adk_ram
    import adk_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 34
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/antidictionary_key_table.sv
// antidictionary key table: set of (key, tag) pairs held in one ram
//
// input channel i_in_valid / o_in_ready carries one word: action, key, bit_tag.
// output channel o_out_valid / i_out_ready returns exactly one word per input:
// found, predicted_bit, removed, store_full and occupancy after the action.
// every action scans the whole entry ram, one entry per cycle through its
// single read port; the next word is taken only after the current
// action's final step. the scan finds matches under both tags and the
// first free entry, then a final step updates the ram where needed.
// after reset a clearing pass writes every entry invalid, one per cycle;
// o_in_ready stays low during that pass.
// a result waits in an output register; the next word is accepted and
// scanned meanwhile, and only the final write step waits for the register
// to drain when the receiver stalls.
module antidictionary_key_table
    import adk_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_BITS + 2;
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    t_state r_state, n_state;

    logic [AW-1:0]       r_addr, n_addr;
    logic                r_issue, n_issue;
    logic                r_pend;
    logic [AW-1:0]       r_pend_idx;
    logic [1:0]          r_act;
    logic [KEY_BITS-1:0] r_key;
    logic                r_tag;
    logic                r_hit0, n_hit0, r_hit1, n_hit1, r_free, n_free;
    logic [AW-1:0]       r_idx0, n_idx0, r_idx1, n_idx1, r_free_idx, n_free_idx;
    logic [CW-1:0]       r_count, n_count;
    logic                r_out_valid;
    t_out_word           r_out, n_out;

    logic            we, re;
    logic [AW-1:0]   waddr;
    logic [EW-1:0]   wdata, rdata;
    logic            ent_valid, ent_tag;
    logic [KEY_BITS-1:0] ent_key;
    logic            other_hit, own_hit;
    logic [AW-1:0]   other_idx;
    logic            out_free, accept;

    adk_ram #(.DEPTH(CAPACITY), .WIDTH(EW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(r_addr),
        .o_rdata(rdata)
    );

    assign {ent_valid, ent_tag, ent_key} = rdata;
    assign out_free  = !r_out_valid || i_out_ready;
    assign accept    = i_in_valid && o_in_ready;
    assign other_hit = r_tag ? r_hit0 : r_hit1;
    assign other_idx = r_tag ? r_idx0 : r_idx1;
    assign own_hit   = r_tag ? r_hit1 : r_hit0;
    assign re        = (r_state == ST_SCAN) && r_issue;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_addr == LAST) n_state = ST_IDLE;
            ST_IDLE:  if (accept) n_state = ST_SCAN;
            ST_SCAN:  if (r_pend && r_pend_idx == LAST) n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // scan bookkeeping
    always_comb begin
        n_addr     = r_addr;
        n_issue    = r_issue;
        n_hit0     = r_hit0;
        n_hit1     = r_hit1;
        n_free     = r_free;
        n_idx0     = r_idx0;
        n_idx1     = r_idx1;
        n_free_idx = r_free_idx;
        case (r_state)
            ST_CLEAR: n_addr = r_addr + 1'b1;
            ST_IDLE: begin
                n_addr  = '0;
                n_issue = 1'b1;
                n_hit0  = 1'b0;
                n_hit1  = 1'b0;
                n_free  = 1'b0;
            end
            ST_SCAN: begin
                if (r_issue) begin
                    if (r_addr == LAST) n_issue = 1'b0;
                    else n_addr = r_addr + 1'b1;
                end
                if (r_pend) begin
                    if (ent_valid && ent_key == r_key) begin
                        if (!ent_tag) begin
                            n_hit0 = 1'b1;
                            n_idx0 = r_pend_idx;
                        end else begin
                            n_hit1 = 1'b1;
                            n_idx1 = r_pend_idx;
                        end
                    end
                    if (!ent_valid && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_pend_idx;
                    end
                end
            end
            default: ;
        endcase
    end

    // update and result
    always_comb begin
        we      = 1'b0;
        waddr   = r_addr;
        wdata   = '0;
        n_count = r_count;
        n_out   = '0;
        case (r_state)
            ST_CLEAR: we = 1'b1;
            ST_DONE: begin
                case (r_act)
                    ACT_LEARN, ACT_LOAD: begin
                        if (r_act == ACT_LEARN && other_hit) begin
                            we            = out_free;
                            waddr         = other_idx;
                            n_count       = r_count - 1'b1;
                            n_out.removed = 1'b1;
                        end else if (!own_hit) begin
                            if (r_free) begin
                                we      = out_free;
                                waddr   = r_free_idx;
                                wdata   = {1'b1, r_tag, r_key};
                                n_count = r_count + 1'b1;
                            end else begin
                                n_out.store_full = 1'b1;
                            end
                        end
                    end
                    ACT_LOOKUP: begin
                        n_out.found         = r_hit0 || r_hit1;
                        n_out.predicted_bit = r_hit0;
                    end
                    default: ;
                endcase
                n_out.occupancy = 11'(n_count);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_issue <= n_issue;
            r_pend  <= re;
            if (r_state == ST_DONE && out_free) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= r_addr;
        r_hit0     <= n_hit0;
        r_hit1     <= n_hit1;
        r_free     <= n_free;
        r_idx0     <= n_idx0;
        r_idx1     <= n_idx1;
        r_free_idx <= n_free_idx;
        if (accept) begin
            r_act <= i_in_word.action;
            r_key <= i_in_word.key[KEY_BITS-1:0];
            r_tag <= i_in_word.bit_tag;
        end
        if (r_state == ST_DONE && out_free) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above capacity");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.store_full |-> r_count == FULL_CNT)
        else $error("insert dropped with free entries left");

    a_removed_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.removed && o_out_word.found))
        else $error("removed and found both set");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLEAR |-> !o_in_ready)
        else $error("word accepted during clearing pass");

endmodule
